// File: rtl/pce_pkg.sv
// Shared types and constants of the PCI bus-0 configuration enumerator.
package pce_pkg;

	// Item kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_FIND  = 2'd2;
	localparam logic [1:0] KIND_WORD  = 2'd3;

	// Result kinds
	localparam logic [1:0] RES_REQUEST = 2'd0;
	localparam logic [1:0] RES_DONE    = 2'd1;
	localparam logic [1:0] RES_FIND    = 2'd2;
	localparam logic [1:0] RES_WORD    = 2'd3;

	// Status codes
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_RANGE     = 2'd1;
	localparam logic [1:0] STS_NOT_READY = 2'd2;

	// Config space layout
	localparam logic [15:0] NO_DEVICE_ID  = 16'hFFFF;
	localparam logic [7:0]  REG_CLASS_REV = 8'h08;
	localparam logic [7:0]  REG_INTERRUPT = 8'h3C;
	localparam logic [7:0]  REG_BAR0      = 8'h10;
	localparam logic [7:0]  REG_MASK      = 8'hFC;
	localparam logic [2:0]  LAST_FUNCTION = 3'd7;
	localparam int          FIXED_WORDS   = 3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] read_data;
		logic [7:0]  entry_index;
		logic [3:0]  word_select;
		logic [15:0] vendor_key;
		logic [15:0] device_key;
	} item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [4:0]  req_device;
		logic [2:0]  req_function;
		logic [7:0]  req_register;
		logic [31:0] word_out;
		logic [6:0]  entry_count;
		logic        match_found;
		logic [5:0]  match_index;
		logic [1:0]  status;
	} result_t;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_PROBE0  = 5'b00010,
		PH_PROBEF  = 5'b00100,
		PH_CAPTURE = 5'b01000,
		PH_DONE    = 5'b10000
	} scan_phase_t;

	typedef enum logic [2:0] {
		ST_READY = 3'b001,
		ST_FIND  = 3'b010,
		ST_WORD  = 3'b100
	} ctrl_state_t;

	// Config register read at a given capture step of one function
	function automatic logic [7:0] step_register(input logic [3:0] step);
		logic [7:0] offs;
		offs = 8'd0;
		if (step == 4'd1)
			offs = REG_CLASS_REV;
		else if (step == 4'd2)
			offs = REG_INTERRUPT;
		else if (step >= 4'd3)
			offs = (REG_BAR0 + {2'b00, 4'(step - 4'd3), 2'b00}) & REG_MASK;
		return offs;
	endfunction

endpackage

// File: rtl/pce_stream_if.sv
// Valid/ready stream channel carrying one payload per request.
interface pce_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/pce_ram.sv
// Generic simple dual-port RAM with registered read.
module pce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 576
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// File: rtl/pci_config_enumerator.sv
// PCI bus-0 configuration enumerator: scan sequencer, descriptor table, find and word read.
//
// A start request from idle launches a scan of bus 0; each scan step (start or returned
// read dword) is answered with the next config read request or a scan-done result, and
// the result sits in an output register so the sink may stall. Per stored function nine
// dwords (3 + BAR_COUNT) go into the descriptor RAM. A find walks the stored ID words
// through the one RAM read port and one comparator, one entry per cycle, and stops at the
// first match or after the last entry. A stored word read passes through the registered
// RAM read into the output register. Find and word read report status 2 until the scan
// has finished. No clearing pass follows reset: only written entries are readable.
module pci_config_enumerator #(
	parameter int MAX_ENTRIES     = 64,
	parameter int DEVICES_PER_BUS = 32,
	parameter int BAR_COUNT       = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	pce_stream_if.sink   item,
	pce_stream_if.source result
);

	localparam int WPE       = pce_pkg::FIXED_WORDS + BAR_COUNT;
	localparam int LAST_STEP = 2 + BAR_COUNT;
	localparam int DEPTH     = MAX_ENTRIES * WPE;
	localparam int AW        = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CMP_W     = (CNT_W > 8) ? CNT_W : 8;

	pce_pkg::scan_phase_t ph_q, ph_n;
	pce_pkg::ctrl_state_t st_q, st_n;
	logic [4:0]       dev_q, dev_n;
	logic [2:0]       fn_q, fn_n;
	logic [3:0]       step_q, step_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [CNT_W-1:0] find_idx_q, find_idx_n;
	logic [IDX_W-1:0] cmp_idx_q, cmp_idx_n;
	logic             cmp_vld_q, cmp_vld_n;
	logic [15:0]      vkey_q, dkey_q;

	pce_pkg::result_t res_q, res_n;
	logic             res_vld_q;
	logic             res_load;

	pce_pkg::item_t   it;
	logic             accept;
	logic             out_free;
	logic             emit, finish, adv_fn, adv_dev;
	logic [5:0]       dev_inc;

	logic             we, re;
	logic [AW-1:0]    waddr, raddr;
	logic [31:0]      rdata;
	logic             id_match;

	assign it       = item.payload;
	assign out_free = !res_vld_q || result.ready;
	assign item.ready = (st_q == pce_pkg::ST_READY) && out_free;
	assign accept   = item.valid && item.ready;
	assign result.valid   = res_vld_q;
	assign result.payload = res_q;
	assign id_match = (rdata[15:0] == vkey_q) && (rdata[31:16] == dkey_q);

	pce_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (it.read_data),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		ph_n       = ph_q;
		st_n       = st_q;
		dev_n      = dev_q;
		fn_n       = fn_q;
		step_n     = step_q;
		cnt_n      = cnt_q;
		find_idx_n = find_idx_q;
		cmp_idx_n  = cmp_idx_q;
		cmp_vld_n  = cmp_vld_q;
		emit       = 1'b0;
		finish     = 1'b0;
		adv_fn     = 1'b0;
		adv_dev    = 1'b0;
		res_load   = 1'b0;
		we         = 1'b0;
		re         = 1'b0;
		waddr      = AW'(cnt_q[IDX_W-1:0]) * AW'(WPE) + AW'(step_q);
		raddr      = AW'(it.entry_index[IDX_W-1:0]) * AW'(WPE) + AW'(it.word_select);
		dev_inc    = {1'b0, dev_q} + 6'd1;
		res_n      = '0;

		unique case (st_q)
			pce_pkg::ST_READY: begin
				if (accept) begin
					unique case (it.kind)
						pce_pkg::KIND_START: begin
							if (ph_q == pce_pkg::PH_IDLE) begin
								cnt_n  = '0;
								dev_n  = '0;
								fn_n   = '0;
								step_n = '0;
								ph_n   = pce_pkg::PH_PROBE0;
								emit   = 1'b1;
							end else if (ph_q == pce_pkg::PH_DONE) begin
								finish = 1'b1;
							end else begin
								emit = 1'b1;
							end
						end
						pce_pkg::KIND_DATA: begin
							if (ph_q == pce_pkg::PH_PROBE0 || ph_q == pce_pkg::PH_PROBEF) begin
								if (it.read_data[15:0] == pce_pkg::NO_DEVICE_ID) begin
									if (ph_q == pce_pkg::PH_PROBE0)
										adv_dev = 1'b1;
									else
										adv_fn = 1'b1;
								end else if (cnt_q >= CNT_W'(MAX_ENTRIES)) begin
									finish = 1'b1;
								end else begin
									// probe dword doubles as the ID word
									we     = 1'b1;
									waddr  = AW'(cnt_q[IDX_W-1:0]) * AW'(WPE);
									step_n = 4'd1;
									ph_n   = pce_pkg::PH_CAPTURE;
									emit   = 1'b1;
								end
							end else if (ph_q == pce_pkg::PH_CAPTURE) begin
								we     = 1'b1;
								step_n = step_q + 4'd1;
								if (step_n <= 4'(LAST_STEP)) begin
									emit = 1'b1;
								end else begin
									cnt_n  = cnt_q + CNT_W'(1);
									adv_fn = 1'b1;
								end
							end
						end
						pce_pkg::KIND_FIND, pce_pkg::KIND_WORD: begin
							res_n.result_kind = it.kind;
							res_n.entry_count = 7'(cnt_q);
							if (ph_q != pce_pkg::PH_DONE) begin
								res_n.status = pce_pkg::STS_NOT_READY;
								res_load     = 1'b1;
							end else if (it.kind == pce_pkg::KIND_FIND) begin
								find_idx_n = '0;
								cmp_vld_n  = 1'b0;
								st_n       = pce_pkg::ST_FIND;
							end else if (CMP_W'(it.entry_index) >= CMP_W'(cnt_q)) begin
								res_n.status = pce_pkg::STS_RANGE;
								res_load     = 1'b1;
							end else if (it.word_select > 4'(LAST_STEP)) begin
								res_load = 1'b1;
							end else begin
								re   = 1'b1;
								st_n = pce_pkg::ST_WORD;
							end
						end
						default: ;
					endcase

					if (adv_fn) begin
						step_n = '0;
						if (fn_q < pce_pkg::LAST_FUNCTION) begin
							fn_n = fn_q + 3'd1;
							ph_n = pce_pkg::PH_PROBEF;
							emit = 1'b1;
						end else begin
							adv_dev = 1'b1;
						end
					end
					if (adv_dev) begin
						fn_n   = '0;
						step_n = '0;
						if (dev_inc < 6'(DEVICES_PER_BUS)) begin
							dev_n = dev_inc[4:0];
							ph_n  = pce_pkg::PH_PROBE0;
							emit  = 1'b1;
						end else begin
							finish = 1'b1;
						end
					end
					if (finish) begin
						ph_n              = pce_pkg::PH_DONE;
						res_n             = '0;
						res_n.result_kind = pce_pkg::RES_DONE;
						res_n.entry_count = 7'(cnt_n);
						res_load          = 1'b1;
					end else if (emit) begin
						res_n              = '0;
						res_n.result_kind  = pce_pkg::RES_REQUEST;
						res_n.req_device   = dev_n;
						res_n.req_function = fn_n;
						res_n.req_register = (ph_n == pce_pkg::PH_CAPTURE) ?
							pce_pkg::step_register(step_n) : 8'd0;
						res_n.entry_count  = 7'(cnt_n);
						res_load           = 1'b1;
					end
				end
			end
			pce_pkg::ST_FIND: begin
				// one read issued and one ID compared per cycle; frozen while output busy
				res_n.result_kind = pce_pkg::RES_FIND;
				res_n.entry_count = 7'(cnt_q);
				raddr = AW'(find_idx_q[IDX_W-1:0]) * AW'(WPE);
				if (out_free) begin
					if (cmp_vld_q && id_match) begin
						res_n.match_found = 1'b1;
						res_n.match_index = 6'(cmp_idx_q);
						res_load          = 1'b1;
						st_n              = pce_pkg::ST_READY;
					end else if (find_idx_q >= cnt_q) begin
						res_load = 1'b1;
						st_n     = pce_pkg::ST_READY;
					end else begin
						re         = 1'b1;
						cmp_vld_n  = 1'b1;
						cmp_idx_n  = find_idx_q[IDX_W-1:0];
						find_idx_n = find_idx_q + CNT_W'(1);
					end
				end
			end
			pce_pkg::ST_WORD: begin
				res_n.result_kind = pce_pkg::RES_WORD;
				res_n.entry_count = 7'(cnt_q);
				res_n.word_out    = rdata;
				if (out_free) begin
					res_load = 1'b1;
					st_n     = pce_pkg::ST_READY;
				end
			end
			default: st_n = pce_pkg::ST_READY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q       <= pce_pkg::PH_IDLE;
			st_q       <= pce_pkg::ST_READY;
			dev_q      <= '0;
			fn_q       <= '0;
			step_q     <= '0;
			cnt_q      <= '0;
			find_idx_q <= '0;
			cmp_idx_q  <= '0;
			cmp_vld_q  <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			ph_q       <= ph_n;
			st_q       <= st_n;
			dev_q      <= dev_n;
			fn_q       <= fn_n;
			step_q     <= step_n;
			cnt_q      <= cnt_n;
			find_idx_q <= find_idx_n;
			cmp_idx_q  <= cmp_idx_n;
			cmp_vld_q  <= cmp_vld_n;
			if (res_load)
				res_vld_q <= 1'b1;
			else if (result.ready)
				res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load)
			res_q <= res_n;
		if (accept) begin
			vkey_q <= it.vendor_key;
			dkey_q <= it.device_key;
		end
	end

endmodule

// File: verif/tb_pci_config_enumerator.sv
`timescale 1ns / 100ps
// Testbench of the PCI bus-0 enumerator: one scripted bus scan, then starts, data, finds and stored word reads.
module tb_pci_config_enumerator;

	localparam int MAX_ENTRIES     = 64;
	localparam int DEVICES_PER_BUS = 32;
	localparam int BAR_COUNT       = 6;
	localparam int WORDS_PER_ENTRY = pce_pkg::FIXED_WORDS + BAR_COUNT;
	localparam int ANSWERED_ITEMS  = 1450;
	localparam int STALL_LIMIT     = 4000;
	localparam int MAX_PRINTED     = 60;

	typedef struct {
		pce_pkg::item_t req;
		bit             drain_first;
	} pending_item_t;

	logic clk;
	logic arst_n;

	pce_stream_if #(.payload_t(pce_pkg::item_t))   item_ch ();
	pce_stream_if #(.payload_t(pce_pkg::result_t)) result_ch ();

	pci_config_enumerator #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.DEVICES_PER_BUS(DEVICES_PER_BUS),
		.BAR_COUNT(BAR_COUNT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	pending_item_t    send_queue[$];
	pce_pkg::result_t awaited_results[$];
	int unsigned      items_accepted;
	int unsigned      results_seen;
	int unsigned      mismatches;
	int unsigned      quiet_cycles;

	// behavioral copy of the scan sequencer and descriptor table
	pce_pkg::scan_phase_t model_phase;
	bit          model_finished;
	bit [4:0]    model_device;
	bit [2:0]    model_function;
	bit [3:0]    model_step;
	bit [6:0]    model_count;
	bit [31:0]   desc_words [MAX_ENTRIES * WORDS_PER_ENTRY];

	// bus layout seen by the stimulus
	bit        fn_present [DEVICES_PER_BUS][8];
	bit [31:0] id_pool [8];
	bit [31:0] recorded_ids [$];
	bit        gen_scanning;
	bit        table_full;
	int        answered;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic pce_pkg::result_t idle_answer();
		pce_pkg::result_t r;
		r = '0;
		r.entry_count = model_count;
		return r;
	endfunction

	function automatic logic [7:0] capture_offset(input bit [3:0] s);
		if (s == 4'd1)
			return pce_pkg::REG_CLASS_REV;
		if (s == 4'd2)
			return pce_pkg::REG_INTERRUPT;
		if (s >= 4'd3)
			return (pce_pkg::REG_BAR0 + 8'(4 * (s - 4'd3))) & pce_pkg::REG_MASK;
		return 8'h00;
	endfunction

	function automatic pce_pkg::result_t read_request();
		pce_pkg::result_t r;
		r = idle_answer();
		r.result_kind = pce_pkg::RES_REQUEST;
		r.req_device = model_device;
		r.req_function = model_function;
		r.req_register = (model_phase == pce_pkg::PH_CAPTURE) ?
			capture_offset(model_step) : 8'h00;
		return r;
	endfunction

	function automatic pce_pkg::result_t scan_done();
		pce_pkg::result_t r;
		model_phase = pce_pkg::PH_DONE;
		model_finished = 1'b1;
		r = idle_answer();
		r.result_kind = pce_pkg::RES_DONE;
		return r;
	endfunction

	function automatic pce_pkg::result_t advance_device();
		model_function = 3'd0;
		model_step = 4'd0;
		if (int'(model_device) + 1 < DEVICES_PER_BUS) begin
			model_device = model_device + 5'd1;
			model_phase = pce_pkg::PH_PROBE0;
			return read_request();
		end
		return scan_done();
	endfunction

	function automatic pce_pkg::result_t advance_function();
		model_step = 4'd0;
		if (model_function < pce_pkg::LAST_FUNCTION) begin
			model_function = model_function + 3'd1;
			model_phase = pce_pkg::PH_PROBEF;
			return read_request();
		end
		return advance_device();
	endfunction

	// works out the answer to one accepted request and queues it, if it gets one
	task automatic predict_answer(input pce_pkg::item_t it);
		pce_pkg::result_t r;
		bit      answers;
		int      base;
		answers = 1'b1;
		r = idle_answer();
		base = int'(model_count) * WORDS_PER_ENTRY;
		case (it.kind)
		pce_pkg::KIND_START: begin
			if (model_phase == pce_pkg::PH_IDLE) begin
				model_count = '0;
				model_device = '0;
				model_function = '0;
				model_step = '0;
				model_phase = pce_pkg::PH_PROBE0;
				r = read_request();
			end else if (model_phase == pce_pkg::PH_DONE) begin
				r = scan_done();
			end else begin
				r = read_request();
			end
		end
		pce_pkg::KIND_DATA: begin
			if (model_phase == pce_pkg::PH_IDLE || model_phase == pce_pkg::PH_DONE) begin
				answers = 1'b0;
			end else if (model_phase != pce_pkg::PH_CAPTURE) begin
				if (it.read_data[15:0] == pce_pkg::NO_DEVICE_ID) begin
					if (model_phase == pce_pkg::PH_PROBE0)
						r = advance_device();
					else
						r = advance_function();
				end else if (model_count >= MAX_ENTRIES) begin
					r = scan_done();
				end else begin
					desc_words[base] = it.read_data;
					model_step = 4'd1;
					model_phase = pce_pkg::PH_CAPTURE;
					r = read_request();
				end
			end else begin
				desc_words[base + model_step] = it.read_data;
				model_step = model_step + 4'd1;
				if (model_step < WORDS_PER_ENTRY) begin
					r = read_request();
				end else begin
					model_count = model_count + 7'd1;
					r = advance_function();
				end
			end
		end
		pce_pkg::KIND_FIND: begin
			r.result_kind = pce_pkg::RES_FIND;
			if (!model_finished) begin
				r.status = pce_pkg::STS_NOT_READY;
			end else begin
				for (int i = 0; i < model_count; i++) begin
					if (desc_words[i * WORDS_PER_ENTRY] == {it.device_key, it.vendor_key}) begin
						r.match_found = 1'b1;
						r.match_index = 6'(i);
						break;
					end
				end
			end
		end
		pce_pkg::KIND_WORD: begin
			r.result_kind = pce_pkg::RES_WORD;
			if (!model_finished)
				r.status = pce_pkg::STS_NOT_READY;
			else if (it.entry_index >= model_count)
				r.status = pce_pkg::STS_RANGE;
			else if (it.word_select < WORDS_PER_ENTRY)
				r.word_out = desc_words[int'(it.entry_index) * WORDS_PER_ENTRY + it.word_select];
		end
		endcase
		if (answers)
			awaited_results.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("Mismatch at result %0d: %s got 0x%0h, want 0x%0h",
				results_seen, what, got, want);
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// traffic mode (sender idle, receiver stall) changes every 160 accepted requests
	function automatic int traffic_mode();
		return (items_accepted / 160) % 4;
	endfunction

	function automatic bit sender_idle();
		case (traffic_mode())
		1: return $urandom_range(0, 99) < 71;
		3: return $urandom_range(0, 99) < 15;
		default: return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stall();
		case (traffic_mode())
		2: return $urandom_range(0, 99) < 71;
		3: return $urandom_range(0, 99) < 15;
		default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.payload <= '0;
		end else begin
			bit go;
			if (item_ch.valid && item_ch.ready) begin
				predict_answer(send_queue[0].req);
				void'(send_queue.pop_front());
				items_accepted++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				go = send_queue.size() != 0 && !sender_idle();
				if (go && send_queue[0].drain_first && awaited_results.size() != 0)
					go = 1'b0;
				item_ch.valid <= go;
				if (go)
					item_ch.payload <= send_queue[0].req;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			pce_pkg::result_t got;
			pce_pkg::result_t want;
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.payload;
				results_seen++;
				if (awaited_results.size() == 0) begin
					report_mismatch("result with nothing awaited, kind",
						32'(got.result_kind), 32'd0);
				end else begin
					want = awaited_results.pop_front();
					check_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
					check_field("req_device", 32'(got.req_device), 32'(want.req_device));
					check_field("req_function", 32'(got.req_function),
						32'(want.req_function));
					check_field("req_register", 32'(got.req_register),
						32'(want.req_register));
					check_field("word_out", got.word_out, want.word_out);
					check_field("entry_count", 32'(got.entry_count), 32'(want.entry_count));
					check_field("match_found", 32'(got.match_found), 32'(want.match_found));
					check_field("match_index", 32'(got.match_index), 32'(want.match_index));
					check_field("status", 32'(got.status), 32'(want.status));
				end
			end
			result_ch.ready <= !receiver_stall();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	function automatic pce_pkg::item_t random_item(input logic [1:0] k);
		pce_pkg::item_t it;
		it.kind = k;
		it.read_data = $urandom;
		it.entry_index = 8'($urandom);
		it.word_select = 4'($urandom);
		it.vendor_key = 16'($urandom);
		it.device_key = 16'($urandom);
		return it;
	endfunction

	function automatic bit [31:0] pattern_word();
		case ($urandom_range(0, 7))
		0: return 32'h0000_0000;
		1: return 32'hFFFF_FFFF;
		default: return $urandom;
		endcase
	endfunction

	// any ID whose vendor half reads as present
	function automatic bit [31:0] fresh_id();
		bit [31:0] v;
		v = $urandom;
		if (v[15:0] == pce_pkg::NO_DEVICE_ID)
			v[0] = 1'b0;
		return v;
	endfunction

	// data while no scan runs is dropped by the block and gets no answer
	task automatic queue_item(input pce_pkg::item_t it, input bit drain_first = 1'b0);
		send_queue.push_back('{it, drain_first});
		if (it.kind != pce_pkg::KIND_DATA || gen_scanning)
			answered++;
	endtask

	task automatic queue_data(input bit [31:0] d);
		pce_pkg::item_t it;
		it = random_item(pce_pkg::KIND_DATA);
		it.read_data = d;
		queue_item(it);
	endtask

	task automatic queue_find(input bit [31:0] id, input bit drain_first = 1'b0);
		pce_pkg::item_t it;
		it = random_item(pce_pkg::KIND_FIND);
		it.vendor_key = id[15:0];
		it.device_key = id[31:16];
		queue_item(it, drain_first);
	endtask

	task automatic queue_word(input int entry, input int sel, input bit drain_first = 1'b0);
		pce_pkg::item_t it;
		it = random_item(pce_pkg::KIND_WORD);
		it.entry_index = 8'(entry);
		it.word_select = 4'(sel);
		queue_item(it, drain_first);
	endtask

	// starts, finds and word reads mixed into the scan
	task automatic scan_noise();
		if ($urandom_range(0, 99) < 6) begin
			case ($urandom_range(0, 2))
			0: queue_item(random_item(pce_pkg::KIND_START));
			1: queue_item(random_item(pce_pkg::KIND_FIND));
			default: queue_item(random_item(pce_pkg::KIND_WORD));
			endcase
		end
	endtask

	// queues every dword the bus would give, in the order the block asks for them
	task automatic build_scan();
		bit        over;
		bit [31:0] id;
		over = 1'b0;
		queue_item(random_item(pce_pkg::KIND_START));
		gen_scanning = 1'b1;
		queue_item(random_item(pce_pkg::KIND_START));
		for (int d = 0; d < DEVICES_PER_BUS && !over; d++) begin
			for (int f = 0; f < 8 && !over; f++) begin
				if (f > 0 && !fn_present[d][0])
					break;
				scan_noise();
				if (!fn_present[d][f]) begin
					queue_data({16'($urandom), pce_pkg::NO_DEVICE_ID});
				end else begin
					if (d == 0 && f < 2)
						id = id_pool[f];
					else if ($urandom_range(0, 99) < 70)
						id = id_pool[$urandom_range(0, 7)];
					else
						id = fresh_id();
					queue_data(id);
					if (recorded_ids.size() == MAX_ENTRIES) begin
						over = 1'b1;
						table_full = 1'b1;
					end else begin
						recorded_ids.push_back(id);
						for (int s = 1; s < WORDS_PER_ENTRY; s++) begin
							if (recorded_ids.size() == 1 && s == 2) begin
								queue_item(random_item(pce_pkg::KIND_START));
								queue_item(random_item(pce_pkg::KIND_FIND));
							end else begin
								scan_noise();
							end
							queue_data(pattern_word());
						end
					end
				end
			end
		end
		gen_scanning = 1'b0;
	endtask

	initial begin
		bit        dense;
		bit        hold;
		int        pick;
		bit [31:0] id;
		arst_n = 1'b0;
		model_phase = pce_pkg::PH_IDLE;
		model_finished = 1'b0;
		model_device = '0;
		model_function = '0;
		model_step = '0;
		model_count = '0;

		// dense layouts fill the table, sparse ones walk every device
		dense = $urandom_range(0, 2) != 0;
		for (int d = 0; d < DEVICES_PER_BUS; d++)
			for (int f = 0; f < 8; f++)
				fn_present[d][f] = $urandom_range(0, 99) <
					((f == 0) ? (dense ? 75 : 50) : (dense ? 45 : 10));
		fn_present[0][0] = 1'b1;
		fn_present[0][1] = 1'b1;
		fn_present[1][0] = 1'b0;
		id_pool[0] = 32'hFFFF_0000;
		id_pool[1] = 32'h0000_FFFE;
		for (int i = 2; i < 8; i++)
			id_pool[i] = fresh_id();

		// before any scan: dropped data, not-ready answers
		queue_data(32'hFFFF_FFFF);
		queue_item(random_item(pce_pkg::KIND_FIND));
		queue_word(0, 0);
		queue_word(255, 15);
		build_scan();

		// after the scan; the first one holds off until the scan answers are in
		queue_item(random_item(pce_pkg::KIND_START), 1'b1);
		queue_item(random_item(pce_pkg::KIND_DATA));
		queue_find(recorded_ids[0]);
		queue_find(32'hFFFF_FFFF);
		queue_find(id_pool[2]);
		queue_word(recorded_ids.size() - 1, 8);
		queue_word(recorded_ids.size(), 0);
		queue_word(255, 15);
		queue_word(0, 9);
		queue_word(0, 1);
		queue_word(0, 2);

		while (answered < ANSWERED_ITEMS) begin
			hold = $urandom_range(0, 199) == 0;
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				queue_item(random_item(pce_pkg::KIND_DATA), hold);
			end else if (pick < 16) begin
				queue_item(random_item(pce_pkg::KIND_START), hold);
			end else if (pick < 50) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					id = recorded_ids[$urandom_range(0, recorded_ids.size() - 1)];
				else if (pick < 80)
					id = id_pool[$urandom_range(0, 7)];
				else
					id = $urandom;
				queue_find(id, hold);
			end else begin
				queue_word(($urandom_range(0, 4) != 0) ?
					$urandom_range(0, recorded_ids.size() - 1) : $urandom_range(0, 255),
					($urandom_range(0, 6) != 0) ? $urandom_range(0, 8) : $urandom_range(0, 15),
					hold);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (send_queue.size() != 0)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		$display("Scan recorded %0d functions %s.", recorded_ids.size(),
			table_full ? "and stopped at a full table" : "across the whole bus");
		$display("%0d requests driven, %0d results checked, %0d mismatches.",
			items_accepted, results_seen, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/pce_pkg.sv
rtl/pce_stream_if.sv
rtl/pce_ram.sv
rtl/pci_config_enumerator.sv
verif/tb_pci_config_enumerator.sv
